>>> rtl/pkbd_pkg.sv
// Package: shared constants, register codes, beat types and sequencer states.
package pkbd_pkg;

  // Field widths fixed by the interface
  localparam int unsigned KEY_W    = 4;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STATUS_W = 10;
  localparam int unsigned LIMIT_W  = 5;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Default sizes handed to the top level parameters
  localparam int unsigned NUM_KEYS_DEF   = 16;
  localparam int unsigned RING_DEPTH_DEF = 16;

  // Client error status range: LO inclusive, HI exclusive
  localparam logic [STATUS_W-1:0] CLIENT_ERR_LO = 10'd400;
  localparam logic [STATUS_W-1:0] CLIENT_ERR_HI = 10'd500;

  // Register reset values
  localparam logic [TIME_W-1:0]  WINDOW_RESET = 32'd300;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 5'd10;
  localparam logic               FLAG_RESET   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG   = 2'd2;

  // Command queue between front and back
  localparam int unsigned CMD_PW    = 1;
  localparam int unsigned CMD_DEPTH = 2 ** CMD_PW;

  // Classified command handed from front to back
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
    logic              flag;
    logic              update;
  } pkbd_cmd_t;

  // Settings the back end needs
  typedef struct packed {
    logic [TIME_W-1:0]  window;
    logic [LIMIT_W-1:0] limit;
  } pkbd_cfg_t;

  // One result beat
  typedef struct packed {
    logic               error_flag;
    logic               rate_alert;
    logic [COUNT_W-1:0] alert_count;
    logic [KEY_W-1:0]   alert_key;
  } pkbd_res_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_META,
    S_RD,
    S_CMP,
    S_FIN,
    S_OUT
  } pkbd_state_e;

endpackage

>>> rtl/per_key_error_burst_detector.sv
// Top level: configuration registers, front and back ends, result port.
//
// Per-key client error burst detector. Each request beat (key, time stamp,
// status) yields exactly one result beat, in order. A 4xx status sets
// error_flag when flag_every_error is on, and for a key below NUM_KEYS it
// appends the stamp to that key's ring, drops front stamps older than the
// window (signed age) and raises rate_alert with the ring count once the
// count reaches error_limit, emptying the ring. A two-beat command queue
// takes requests while the back end works. A request that touches no ring
// goes straight to the result register; otherwise the ring sequencer
// evicts at most RING_DEPTH stamps, reading one stamp per cycle from the
// single-read-port stamp memory. No clearing pass follows reset: per-key
// valid bits mark rings that were never written. Write configuration only
// while idle.
module per_key_error_burst_detector
  import pkbd_pkg::*;
#(
  parameter int unsigned NUM_KEYS   = NUM_KEYS_DEF,
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request side
  input  logic                 push,
  output logic                 full,
  input  logic [KEY_W-1:0]     key_index_i,
  input  logic [TIME_W-1:0]    event_time_i,
  input  logic [STATUS_W-1:0]  status_code_i,
  // result side
  output logic                 empty,
  input  logic                 pop,
  output logic                 error_flag_o,
  output logic                 rate_alert_o,
  output logic [COUNT_W-1:0]   alert_count_o,
  output logic [KEY_W-1:0]     alert_key_o,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TIME_W-1:0]    cfg_data_i
);

  logic [TIME_W-1:0]  window_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               flag_every_q;
  pkbd_cfg_t          cfg;
  logic               cmd_valid;
  logic               cmd_pop;
  pkbd_cmd_t          cmd;
  logic               res_valid;
  pkbd_res_t          res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= WINDOW_RESET;
      limit_q      <= LIMIT_RESET;
      flag_every_q <= FLAG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW: window_q     <= cfg_data_i;
        CFG_LIMIT:  limit_q      <= cfg_data_i[LIMIT_W-1:0];
        CFG_FLAG:   flag_every_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.window = window_q;
    cfg.limit  = limit_q;
  end

  // Classify and queue requests
  pkbd_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .key_index_i   (key_index_i),
    .event_time_i  (event_time_i),
    .status_code_i (status_code_i),
    .flag_every_i  (flag_every_q),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // Ring update and alert check
  pkbd_back #(
    .NUM_KEYS   (NUM_KEYS),
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign empty         = ~res_valid;
  assign error_flag_o  = res.error_flag;
  assign rate_alert_o  = res.rate_alert;
  assign alert_count_o = res.alert_count;
  assign alert_key_o   = res.alert_key;

  // The back end only takes a command the queue holds
  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command taken from an empty queue");

  // An accepted request is waiting in the queue next cycle
  a_push_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> cmd_valid)
    else $error("accepted request not queued");

  // A result without alert carries a zero count
  a_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !rate_alert_o |-> alert_count_o == '0)
    else $error("alert count set without rate alert");

  // A waiting result is not dropped before it is taken
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result lost before pop");

endmodule

>>> rtl/pkbd_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pkbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pkbd_front.sv
// Front end: classify requests and queue them as commands for the back end.
module pkbd_front
  import pkbd_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [KEY_W-1:0]    key_index_i,
  input  logic [TIME_W-1:0]   event_time_i,
  input  logic [STATUS_W-1:0] status_code_i,
  input  logic                flag_every_i,
  output logic                cmd_valid_o,
  output pkbd_cmd_t           cmd_o,
  input  logic                cmd_pop_i
);

  localparam int unsigned CmpW = 9;

  pkbd_cmd_t          mem_q [CMD_DEPTH];
  logic [CMD_PW-1:0]  wptr_q, wptr_d;
  logic [CMD_PW-1:0]  rptr_q, rptr_d;
  logic [CMD_PW:0]    cnt_q, cnt_d;
  logic               client_err;
  logic               key_ok;
  logic               accept;
  pkbd_cmd_t          cmd_in;

  // Classify the incoming request
  assign client_err = (status_code_i >= CLIENT_ERR_LO) && (status_code_i < CLIENT_ERR_HI);
  assign key_ok     = CmpW'(key_index_i) < CmpW'(NUM_KEYS);

  always_comb begin
    cmd_in.key    = key_index_i;
    cmd_in.stamp  = event_time_i;
    cmd_in.flag   = client_err & flag_every_i;
    cmd_in.update = client_err & key_ok;
  end

  assign full_o      = (cnt_q == (CMD_PW+1)'(CMD_DEPTH));
  assign accept      = push_i & ~full_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rptr_q];

  // Advance pointers and fill level
  always_comb begin
    wptr_d = accept ? wptr_q + CMD_PW'(1) : wptr_q;
    rptr_d = cmd_pop_i ? rptr_q + CMD_PW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (accept && !cmd_pop_i) begin
      cnt_d = cnt_q + (CMD_PW+1)'(1);
    end else if (!accept && cmd_pop_i) begin
      cnt_d = cnt_q - (CMD_PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wptr_q] <= cmd_in;
    end
  end

endmodule

>>> rtl/pkbd_back.sv
// Back end: per-key ring update, stale stamp eviction, alert check and result register.
module pkbd_back
  import pkbd_pkg::*;
#(
  parameter int unsigned NUM_KEYS   = NUM_KEYS_DEF,
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pkbd_cfg_t cfg_i,
  input  logic      cmd_valid_i,
  input  pkbd_cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      res_valid_o,
  output pkbd_res_t res_o,
  input  logic      res_pop_i
);

  localparam int unsigned KW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned HW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(RING_DEPTH + 1);
  localparam int unsigned MW    = HW + CW;
  localparam int unsigned SLOTS = NUM_KEYS * RING_DEPTH;
  localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CMPW  = (CW > LIMIT_W) ? CW : LIMIT_W;

  pkbd_state_e         state_q, state_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [TIME_W-1:0]   stamp_q, stamp_d;
  logic                flag_q, flag_d;
  logic [HW-1:0]       head_q, head_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                alert_q, alert_d;
  logic [COUNT_W-1:0]  acnt_q, acnt_d;
  logic [NUM_KEYS-1:0] valid_q, valid_d;
  pkbd_res_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [KW-1:0]       key_idx;
  logic                meta_re, meta_we;
  logic [KW-1:0]       meta_raddr;
  logic [MW-1:0]       meta_wdata, meta_rdata;
  logic [HW-1:0]       meta_head;
  logic [CW-1:0]       meta_cnt;
  logic                ring_full;
  logic [HW:0]         pos_sum;
  logic [HW-1:0]       push_pos;
  logic                stamp_we, stamp_re;
  logic [AW-1:0]       stamp_waddr, stamp_raddr;
  logic [TIME_W-1:0]   stamp_rdata;
  logic [HW-1:0]       head_next, rd_head;
  logic [TIME_W:0]     diff;
  logic                evict;
  logic                alert;
  logic                out_free;

  // Flat store address of one ring slot
  function automatic logic [AW-1:0] slot_addr(input logic [KW-1:0] k, input logic [HW-1:0] p);
    return AW'(k) * AW'(RING_DEPTH) + AW'(p);
  endfunction

  // Ring position plus one, wrapping at the depth
  function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] h);
    return (h == HW'(RING_DEPTH - 1)) ? '0 : h + HW'(1);
  endfunction

  assign key_idx = KW'(key_q);

  // Per-key head and count; a key never written reads as an empty ring
  assign meta_head = valid_q[key_idx] ? meta_rdata[CW +: HW] : '0;
  assign meta_cnt  = valid_q[key_idx] ? meta_rdata[CW-1:0]   : '0;

  // Push slot: overwrite the oldest on a full ring, else append
  assign ring_full = meta_cnt >= CW'(RING_DEPTH);
  assign pos_sum   = (HW+1)'(meta_head) + (HW+1)'(meta_cnt);
  always_comb begin
    if (ring_full) begin
      push_pos = meta_head;
    end else if (pos_sum >= (HW+1)'(RING_DEPTH)) begin
      push_pos = HW'(pos_sum - (HW+1)'(RING_DEPTH));
    end else begin
      push_pos = HW'(pos_sum);
    end
  end

  // Eviction read: read ahead at the next front while evicting
  assign head_next   = head_inc(head_q);
  assign rd_head     = (state_q == S_CMP) ? head_next : head_q;
  assign stamp_raddr = slot_addr(key_idx, rd_head);
  assign stamp_waddr = slot_addr(key_idx, push_pos);

  // Signed age of the front stamp against the window
  assign diff  = {1'b0, stamp_q} - {1'b0, stamp_rdata};
  assign evict = $signed(diff) > $signed({1'b0, cfg_i.window});

  assign alert    = CMPW'(cnt_q) >= CMPW'(cfg_i.limit);
  assign out_free = ~out_valid_q | res_pop_i;

  assign meta_raddr = KW'(cmd_i.key);
  assign meta_wdata = {head_q, alert ? CW'(0) : cnt_q};

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    stamp_d     = stamp_q;
    flag_d      = flag_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    alert_d     = alert_q;
    acnt_d      = acnt_q;
    valid_d     = valid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~res_pop_i;
    cmd_pop_o   = 1'b0;
    meta_re     = 1'b0;
    meta_we     = 1'b0;
    stamp_we    = 1'b0;
    stamp_re    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          key_d     = cmd_i.key;
          stamp_d   = cmd_i.stamp;
          flag_d    = cmd_i.flag;
          alert_d   = 1'b0;
          acnt_d    = '0;
          if (cmd_i.update) begin
            meta_re = 1'b1;
            state_d = S_META;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_META: begin
        stamp_we = 1'b1;
        if (ring_full) begin
          head_d = head_inc(meta_head);
          cnt_d  = CW'(RING_DEPTH);
        end else begin
          head_d = meta_head;
          cnt_d  = meta_cnt + CW'(1);
        end
        state_d = S_RD;
      end
      S_RD: begin
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          stamp_re = 1'b1;
          state_d  = S_CMP;
        end
      end
      S_CMP: begin
        if (evict) begin
          head_d = head_next;
          cnt_d  = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_d = S_FIN;
          end else begin
            stamp_re = 1'b1;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        meta_we          = 1'b1;
        valid_d[key_idx] = 1'b1;
        alert_d          = alert;
        acnt_d           = alert ? COUNT_W'(cnt_q) : '0;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_d.error_flag  = flag_q;
          out_d.rate_alert  = alert_q;
          out_d.alert_count = acnt_q;
          out_d.alert_key   = key_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    stamp_q <= stamp_d;
    flag_q  <= flag_d;
    head_q  <= head_d;
    cnt_q   <= cnt_d;
    alert_q <= alert_d;
    acnt_q  <= acnt_d;
    out_q   <= out_d;
  end

  // Per-key head and count
  pkbd_ram #(
    .WIDTH (MW),
    .DEPTH (NUM_KEYS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (key_idx),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  // Time stamp rings of all keys
  pkbd_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SLOTS)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (stamp_waddr),
    .wdata_i (stamp_q),
    .re_i    (stamp_re),
    .raddr_i (stamp_raddr),
    .rdata_o (stamp_rdata)
  );

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
